// File: hdl/u8s_pkg.sv
// UTF-8 sanitizer shared definitions: payload structs, run record, byte constants
// and the lead-byte classifier. No dependencies.
package u8s_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int RUN_MAX = 4;

	localparam logic [7:0] REPL_BYTE   = 8'h3F;
	localparam logic [7:0] CONT_LO     = 8'h80;
	localparam logic [7:0] CONT_HI     = 8'hBF;
	localparam logic [7:0] LEAD2_LO    = 8'hC2;
	localparam logic [7:0] LEAD2_HI    = 8'hDF;
	localparam logic [7:0] LEAD_E0     = 8'hE0;
	localparam logic [7:0] LEAD_ED     = 8'hED;
	localparam logic [7:0] LEAD_F0     = 8'hF0;
	localparam logic [7:0] LEAD_F4     = 8'hF4;
	localparam logic [7:0] E0_LO       = 8'hA0;
	localparam logic [7:0] ED_HI       = 8'h9F;
	localparam logic [7:0] F0_LO       = 8'h90;
	localparam logic [7:0] F4_HI       = 8'h8F;

	localparam logic [2:0] LEN_BAD = 3'd0;
	localparam logic [2:0] LEN_ONE = 3'd1;
	localparam logic [2:0] LEN_TWO = 3'd2;
	localparam logic [2:0] LEN_THR = 3'd3;
	localparam logic [2:0] LEN_FOU = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_last;
	} out_item_t;

	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [2:0]              num;
		logic                    last;
	} run_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = LEN_BAD;
		if (!b[7]) begin
			len = LEN_ONE;
		end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			len = LEN_TWO;
		end else if (b[7:4] == LEAD_E0[7:4]) begin
			len = LEN_THR;
		end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
			len = LEN_FOU;
		end
		return len;
	endfunction

endpackage

// File: hdl/u8s_front.sv
// UTF-8 sanitizer front: holds pending sequence bytes and turns each request
// into one run record of zero to four bytes. Depends on u8s_pkg.
module u8s_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  u8s_pkg::in_item_t in_item,
	input  logic              q_full,
	output logic              push,
	output u8s_pkg::run_t     push_run
);
	import u8s_pkg::*;

	logic [7:0] held_q [3];
	logic [1:0] cnt_q;
	logic [2:0] len_q;

	logic [7:0] b;
	logic [7:0] lo;
	logic [7:0] hi;
	logic       in_rng;
	logic [2:0] lead;
	logic [1:0] nxt_cnt;
	logic [2:0] nxt_len;
	logic       wr;
	logic [1:0] wr_idx;
	logic       accept;
	run_t       run;

	assign b        = in_item.in_byte;
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && (run.num != 3'd0);
	assign push_run = run;

	always_comb begin
		lo = CONT_LO;
		hi = CONT_HI;
		if (cnt_q == 2'd1) begin
			case (held_q[0])
				LEAD_E0: lo = E0_LO;
				LEAD_ED: hi = ED_HI;
				LEAD_F0: lo = F0_LO;
				LEAD_F4: hi = F4_HI;
				default: ;
			endcase
		end
		in_rng = (b >= lo) && (b <= hi);
		lead   = lead_len(b);

		run.bytes = {RUN_MAX{REPL_BYTE}};
		run.num   = 3'd0;
		run.last  = in_item.end_of_string;
		nxt_cnt   = cnt_q;
		nxt_len   = len_q;
		wr        = 1'b0;
		wr_idx    = 2'd0;

		if (cnt_q != 2'd0 && in_rng) begin
			if ({1'b0, cnt_q} + 3'd1 >= len_q) begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < cnt_q) begin
						run.bytes[i] = held_q[i];
					end
				end
				run.bytes[cnt_q] = b;
				run.num          = {1'b0, cnt_q} + 3'd1;
				nxt_cnt          = 2'd0;
				nxt_len          = 3'd0;
			end else begin
				wr      = 1'b1;
				wr_idx  = cnt_q;
				nxt_cnt = cnt_q + 2'd1;
			end
		end else begin
			run.num = {1'b0, cnt_q};
			if (lead == LEN_BAD) begin
				run.num = {1'b0, cnt_q} + 3'd1;
				nxt_cnt = 2'd0;
				nxt_len = 3'd0;
			end else if (lead == LEN_ONE) begin
				run.bytes[cnt_q] = b;
				run.num          = {1'b0, cnt_q} + 3'd1;
				nxt_cnt          = 2'd0;
				nxt_len          = 3'd0;
			end else begin
				wr      = 1'b1;
				wr_idx  = 2'd0;
				nxt_cnt = 2'd1;
				nxt_len = lead;
			end
		end

		if (in_item.end_of_string) begin
			run.num = run.num + {1'b0, nxt_cnt};
			nxt_cnt = 2'd0;
			nxt_len = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			len_q <= 3'd0;
		end else if (accept) begin
			cnt_q <= nxt_cnt;
			len_q <= nxt_len;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr) begin
			held_q[wr_idx] <= b;
		end
	end

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> run.num <= 3'(RUN_MAX))
		else $error("run longer than four bytes");

	a_last_yields: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_item.end_of_string |-> push)
		else $error("final byte produced no run");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_item.end_of_string |=> cnt_q == 2'd0 && len_q == 3'd0)
		else $error("pending sequence survived end of string");

endmodule

// File: hdl/u8s_queue.sv
// UTF-8 sanitizer run queue: a small register queue of run records between
// front and back. Depends on u8s_pkg.
module u8s_queue #(
	parameter int DEPTH = u8s_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  u8s_pkg::run_t push_run,
	output logic          full,
	output logic          head_valid,
	output u8s_pkg::run_t head_run,
	input  logic          pop
);
	import u8s_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	run_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_run   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_run;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

// File: hdl/u8s_back.sv
// UTF-8 sanitizer back: walks the head run record to the output register one
// byte per cycle unless stalled; tags run and string ends. Depends on u8s_pkg.
module u8s_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  u8s_pkg::run_t      head_run,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output u8s_pkg::out_item_t out_item
);
	import u8s_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       load;
	logic       at_end;

	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign at_end    = ({1'b0, idx_q} + 3'd1 == head_run.num);
	assign pop       = load && at_end;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte    <= head_run.bytes[idx_q];
			out_q.run_last    <= at_end;
			out_q.string_last <= at_end && head_run.last;
		end
	end

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> {1'b0, idx_q} < head_run.num)
		else $error("byte index beyond run length");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == 2'd0)
		else $error("byte index left nonzero with no run");

	a_string_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.string_last |-> out_q.run_last)
		else $error("string end not on a run end");

endmodule

// File: hdl/utf8_sanitizer_stream_unit.sv
// UTF-8 sanitizer top level: front classifier, run queue and byte emitter.
// Depends on u8s_pkg, u8s_front, u8s_queue and u8s_back.
//
// Takes one input byte per cycle while the run queue is not full and emits one
// output byte per cycle while runs wait and out_stall is low. Each input byte
// yields a run of zero to four output bytes: passed bytes of a complete
// well-formed UTF-8 sequence, '?' for each held byte of a broken one, or '?'
// for each byte that cannot start one; a flagged final byte flushes any
// unfinished sequence as '?' bytes and always yields at least one output. Runs
// wait in a queue of QUEUE_DEPTH records, and input stalls only while that
// queue is full. Output bytes carry run_last on the last byte of each run and
// string_last on the last byte of the string.
module utf8_sanitizer_stream_unit #(
	parameter int QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  u8s_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output u8s_pkg::out_item_t out_item
);
	import u8s_pkg::*;

	logic q_full;
	logic push;
	run_t push_run;
	logic head_valid;
	run_t head_run;
	logic pop;

	u8s_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_full   (q_full),
		.push     (push),
		.push_run (push_run)
	);

	u8s_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_run   (push_run),
		.full       (q_full),
		.head_valid (head_valid),
		.head_run   (head_run),
		.pop        (pop)
	);

	u8s_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_run   (head_run),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

// File: dv/utf8_sanitizer_stream_unit_test.sv
// Testbench for utf8_sanitizer_stream_unit: directed and random byte strings checked
// against a UTF-8 sanitizing predictor, with random idling on both handshakes.
// Depends on u8s_pkg and the utf8_sanitizer_stream_unit RTL.
module utf8_sanitizer_stream_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import u8s_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_ITEMS = 176;
	localparam int CALM_TAIL = 40;
	localparam int MAX_PRINTS = 50;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	logic [7:0] pend_bytes [3];
	int         pend_cnt;
	int         seq_len;
	logic [7:0] run_bytes [$];
	out_item_t  sanitized_q [$];
	logic [7:0] str_bytes [$];

	int  error_count;
	int  cycle_count;
	bit  idle_on;

	utf8_sanitizer_stream_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTS)
			$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic add_run_byte(input logic [7:0] v);
		run_bytes = {run_bytes, v};
	endtask

	task automatic add_str_byte(input logic [7:0] v);
		str_bytes = {str_bytes, v};
	endtask

	function automatic int char_len(input logic [7:0] b);
		if (b < 8'h80)
			return 1;
		if (b >= LEAD2_LO && b <= LEAD2_HI)
			return 2;
		if (b >= LEAD_E0 && b <= 8'hEF)
			return 3;
		if (b >= LEAD_F0 && b <= LEAD_F4)
			return 4;
		return 0;
	endfunction

	task automatic start_char(input logic [7:0] b);
		int len;
		len = char_len(b);
		if (len == 0) begin
			add_run_byte(REPL_BYTE);
		end else if (len == 1) begin
			add_run_byte(b);
		end else begin
			pend_bytes[0] = b;
			pend_cnt = 1;
			seq_len = len;
		end
	endtask

	task automatic sanitize_request(input in_item_t req);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] b;
		out_item_t  res;
		b = req.in_byte;
		lo = CONT_LO;
		hi = CONT_HI;
		run_bytes = {};
		if (pend_cnt == 0) begin
			start_char(b);
		end else begin
			if (pend_cnt == 1) begin
				case (pend_bytes[0])
					LEAD_E0: lo = E0_LO;
					LEAD_ED: hi = ED_HI;
					LEAD_F0: lo = F0_LO;
					LEAD_F4: hi = F4_HI;
					default: ;
				endcase
			end
			if (b >= lo && b <= hi) begin
				if (pend_cnt + 1 >= seq_len) begin
					for (int i = 0; i < pend_cnt; i++)
						add_run_byte(pend_bytes[i]);
					add_run_byte(b);
					pend_cnt = 0;
					seq_len = 0;
				end else begin
					pend_bytes[pend_cnt] = b;
					pend_cnt++;
				end
			end else begin
				for (int i = 0; i < pend_cnt; i++)
					add_run_byte(REPL_BYTE);
				pend_cnt = 0;
				seq_len = 0;
				start_char(b);
			end
		end
		if (req.end_of_string) begin
			for (int i = 0; i < pend_cnt; i++)
				add_run_byte(REPL_BYTE);
			pend_cnt = 0;
			seq_len = 0;
		end
		foreach (run_bytes[k]) begin
			res.out_byte = run_bytes[k];
			res.run_last = (k == run_bytes.size() - 1);
			res.string_last = res.run_last && req.end_of_string;
			sanitized_q = {sanitized_q, res};
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sanitized_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %h run_last %b string_last %b",
					out_item.out_byte, out_item.run_last, out_item.string_last));
			end else begin
				want = sanitized_q.pop_front();
				if (out_item.out_byte !== want.out_byte
						|| out_item.run_last !== want.run_last
						|| out_item.string_last !== want.string_last)
					report_mismatch($sformatf(
						"got byte %h run_last %b string_last %b, want %h %b %b",
						out_item.out_byte, out_item.run_last, out_item.string_last,
						want.out_byte, want.run_last, want.string_last));
			end
		end
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && arst_n && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(input logic [7:0] b, input logic eos);
		in_item_t req;
		req.in_byte = b;
		req.end_of_string = eos;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		do
			@(posedge clk);
		while (in_stall);
		sanitize_request(req);
	endtask

	task automatic test_single_bytes();
		send_request(8'h00, 1'b0);
		send_request(8'h7F, 1'b0);
		send_request(8'h80, 1'b0);
		send_request(8'hC1, 1'b0);
		send_request(8'hF5, 1'b0);
		send_request(8'hFF, 1'b1);
	endtask

	task automatic test_full_sequences();
		send_request(8'hE0, 1'b0);
		send_request(8'hA0, 1'b0);
		send_request(8'h80, 1'b0);
		send_request(8'hF4, 1'b0);
		send_request(8'h8F, 1'b0);
		send_request(8'hBF, 1'b0);
		send_request(8'hBF, 1'b1);
	endtask

	task automatic test_broken_sequences();
		send_request(8'hED, 1'b0);
		send_request(8'hA0, 1'b0);
		send_request(8'hF0, 1'b0);
		send_request(8'h8F, 1'b0);
		send_request(8'hC2, 1'b0);
		send_request(8'h41, 1'b1);
	endtask

	task automatic test_end_flush();
		// broken three-byte prefix, then a lead on the final byte: four results
		send_request(8'hF0, 1'b0);
		send_request(8'h90, 1'b0);
		send_request(8'h80, 1'b0);
		send_request(8'hC2, 1'b1);
		send_request(8'hE1, 1'b1);
	endtask

	task automatic gen_char();
		logic [7:0] lead;
		int         lo;
		int         hi;
		int         kind;
		kind = $urandom_range(0, 9);
		lo = 8'h80;
		hi = 8'hBF;
		case (kind)
			0, 1, 2, 3: add_str_byte(8'($urandom_range(0, 8'h7F)));
			4, 5: begin
				add_str_byte(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
				add_str_byte(8'($urandom_range(lo, hi)));
			end
			6, 7: begin
				lead = 8'($urandom_range(LEAD_E0, 8'hEF));
				if (lead == LEAD_E0)
					lo = E0_LO;
				if (lead == LEAD_ED)
					hi = ED_HI;
				add_str_byte(lead);
				add_str_byte(8'($urandom_range(lo, hi)));
				add_str_byte(8'($urandom_range(8'h80, 8'hBF)));
			end
			8: begin
				lead = 8'($urandom_range(LEAD_F0, LEAD_F4));
				if (lead == LEAD_F0)
					lo = F0_LO;
				if (lead == LEAD_F4)
					hi = F4_HI;
				add_str_byte(lead);
				add_str_byte(8'($urandom_range(lo, hi)));
				add_str_byte(8'($urandom_range(8'h80, 8'hBF)));
				add_str_byte(8'($urandom_range(8'h80, 8'hBF)));
			end
			default: begin
				case ($urandom_range(0, 2))
					0: add_str_byte(8'($urandom_range(0, 255)));
					1: begin
						// truncated sequence
						lead = 8'($urandom_range(LEAD2_LO, LEAD_F4));
						add_str_byte(lead);
						if (char_len(lead) > 2 && $urandom_range(0, 1))
							add_str_byte(8'($urandom_range(8'h80, 8'hBF)));
					end
					default: begin
						// second byte just outside the narrowed range
						case ($urandom_range(0, 3))
							0: begin
								add_str_byte(LEAD_E0);
								add_str_byte(8'($urandom_range(8'h80, 8'h9F)));
							end
							1: begin
								add_str_byte(LEAD_ED);
								add_str_byte(8'($urandom_range(8'hA0, 8'hBF)));
							end
							2: begin
								add_str_byte(LEAD_F0);
								add_str_byte(8'($urandom_range(8'h80, 8'h8F)));
							end
							default: begin
								add_str_byte(LEAD_F4);
								add_str_byte(8'($urandom_range(8'h90, 8'hFF)));
							end
						endcase
					end
				endcase
			end
		endcase
	endtask

	task automatic test_random_strings();
		int sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			str_bytes = {};
			repeat ($urandom_range(1, 8)) gen_char();
			if (sent >= RANDOM_ITEMS - CALM_TAIL)
				idle_on = 1'b0;
			foreach (str_bytes[i])
				send_request(str_bytes[i], i == str_bytes.size() - 1);
			sent += str_bytes.size();
		end
	endtask

	initial begin
		error_count = 0;
		cycle_count = 0;
		pend_cnt = 0;
		seq_len = 0;
		idle_on = 1'b1;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_bytes();
		test_full_sequences();
		test_broken_sequences();
		test_end_flush();
		test_random_strings();
		in_valid <= 1'b0;
		while (sanitized_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
